// ----- hw/rtl/huffman_bit_packing_encoder_assert.svh -----
// ---------------------------------------------------------------------------
// huffman_bit_packing_encoder_assert.svh
// assertion macros used by the encoder checker
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_PACKING_ENCODER_ASSERT_SVH
`define HUFFMAN_BIT_PACKING_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HBPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hbpe_pkg.sv -----
// ---------------------------------------------------------------------------
// hbpe_pkg
// shared constants, opcodes and stage types of the huffman bit packer
// ---------------------------------------------------------------------------
package hbpe_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int ACC_W  = 40;
  localparam int PEND_W = 4;
  localparam int TOT_W  = 32;
  localparam int BYTE_W = 8;
  localparam int NUM_BYTES = 4;
  localparam int OUT_W  = NUM_BYTES * BYTE_W;
  localparam int CNT_W  = 3;
  localparam int VB_W   = 4;
  localparam int CAP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // item in flight between table read and packer
  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] word;
  } item_t;

  // group of result beats handed to the output buffer
  typedef struct packed {
    logic [OUT_W-1:0] bytes;
    logic [CNT_W-1:0] cnt;
    logic [VB_W-1:0]  vbits;
    logic             last;
    logic [TOT_W-1:0] total;
  } group_t;

endpackage

// ----- hw/rtl/huffman_bit_packing_encoder.sv -----
// an accepted beat is registered in the table stage, then its bytes are registered in the output buffer
// throughput: one input beat per cycle while each item yields at most one byte and the output does not stall
// an encode yielding k bytes (up to four) holds the input, once the next byte-producing item
// reaches the packer, until the one-group output buffer has sent those bytes
// loads, flushes and zero-length codes also pass at one beat per cycle while the output does not stall
// reset clears the accumulator, bit total and pipeline and stalls the input; the table keeps its contents
// ---------------------------------------------------------------------------
// huffman_bit_packing_encoder
// huffman encoder with loadable code table packing code bits into bytes
// ---------------------------------------------------------------------------
module huffman_bit_packing_encoder
  import hbpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               sym_valid,
  output logic               sym_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         symbol,
  input  logic [CODE_W-1:0]  code_bits,
  input  logic [LEN_W-1:0]   code_length,
  // result channel
  output logic               byte_valid,
  input  logic               byte_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [VB_W-1:0]    valid_bits,
  output logic               last,
  output logic [TOT_W-1:0]   total_bits
);

  item_t  item;
  group_t grp;
  logic   hold;
  logic   push;
  logic   out_free;
  logic   accept;

  // stall in reset, or when the packer has an item whose bytes cannot enter the buffer
  assign sym_stall = hold || rst;
  assign accept    = sym_valid && !sym_stall;

  // stage 1: table write on load, registered table read on encode
  hbpe_table u_table (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .advance     (!hold),
    .opcode      (opcode),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .item        (item)
  );

  // stage 2: append code to accumulator, cut full bytes or the flush byte
  hbpe_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .out_free (out_free),
    .hold     (hold),
    .push     (push),
    .grp      (grp)
  );

  // output buffer drains one byte per result beat
  hbpe_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .grp        (grp),
    .stall      (byte_stall),
    .valid      (byte_valid),
    .out_free   (out_free),
    .out_byte   (out_byte),
    .valid_bits (valid_bits),
    .last       (last),
    .total_bits (total_bits)
  );

endmodule

// ----- hw/rtl/hbpe_table.sv -----
// ---------------------------------------------------------------------------
// hbpe_table
// code table memory and input register stage
// ---------------------------------------------------------------------------
module hbpe_table
  import hbpe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                advance,
  input  logic [1:0]          opcode,
  input  logic [7:0]          symbol,
  input  logic [CODE_W-1:0]   code_bits,
  input  logic [LEN_W-1:0]    code_length,
  output item_t               item
);

  logic [LEN_W+CODE_W-1:0] mem [SYMBOLS];

  logic [LEN_W+CODE_W-1:0] entry;
  logic                    item_valid;
  logic                    item_flush;

  logic                    is_load;
  logic                    is_enc;
  logic                    is_flush;
  logic                    in_range;
  logic [SYM_W-1:0]        idx;
  logic [LEN_W-1:0]        len_cap;
  logic [CODE_W:0]         mask_wide;
  logic [CODE_W-1:0]       word_masked;

  always_comb begin
    is_load  = 1'b0;
    is_enc   = 1'b0;
    is_flush = 1'b0;
    unique case (opcode)
      OP_LOAD:   is_load  = 1'b1;
      OP_ENCODE: is_enc   = 1'b1;
      OP_FLUSH:  is_flush = 1'b1;
      default:   ;
    endcase
  end

  assign in_range    = (32'(symbol) < SYMBOLS);
  assign idx         = symbol[SYM_W-1:0];
  assign len_cap     = (32'(code_length) > CAP_LEN) ? LEN_W'(CAP_LEN) : code_length;
  assign mask_wide   = ((CODE_W+1)'(1) << len_cap) - (CODE_W+1)'(1);
  assign word_masked = code_bits & mask_wide[CODE_W-1:0];

  // table write on load, registered read on every accepted beat
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      mem[idx] <= {len_cap, word_masked};
    end
    if (accept) begin
      entry <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item_flush <= 1'b0;
    end else if (advance) begin
      item_valid <= accept && ((is_enc && in_range) || is_flush);
      item_flush <= is_flush;
    end
  end

  assign item = {item_valid, item_flush, entry};

endmodule

// ----- hw/rtl/hbpe_pack.sv -----
// ---------------------------------------------------------------------------
// hbpe_pack
// bit accumulator: appends a code, splits off full bytes, handles flush
// ---------------------------------------------------------------------------
module hbpe_pack
  import hbpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    out_free,
  output logic    hold,
  output logic    push,
  output group_t  grp
);

  logic [BYTE_W-1:0] acc;
  logic [PEND_W-1:0] pend;
  logic [TOT_W-1:0]  total;

  logic [ACC_W-1:0]  comb;
  logic [LEN_W-1:0]  t;
  logic [CNT_W-1:0]  nb;
  logic [LEN_W-1:0]  r;
  logic [LEN_W-1:0]  sh;
  logic [ACC_W-1:0]  aligned;
  logic [BYTE_W:0]   mask_wide;
  logic [BYTE_W-1:0] acc_next;
  logic [TOT_W-1:0]  total_next;
  logic [BYTE_W-1:0] flush_byte;
  logic              need;
  logic              go;

  always_comb begin
    comb       = (ACC_W'(acc) << item.len) | ACC_W'(item.word);
    t          = LEN_W'(pend) + item.len;
    nb         = (t > LEN_W'(8)) ? CNT_W'((t - LEN_W'(1)) >> 3) : CNT_W'(0);
    r          = t - {nb, 3'b000};
    sh         = LEN_W'(ACC_W) - t;
    aligned    = comb << sh;
    mask_wide  = ((BYTE_W+1)'(1) << r[PEND_W-1:0]) - (BYTE_W+1)'(1);
    acc_next   = comb[BYTE_W-1:0] & mask_wide[BYTE_W-1:0];
    total_next = total + TOT_W'(item.len);
    flush_byte = BYTE_W'(acc << (PEND_W'(8) - pend));

    need = item.valid && (item.flush || (nb != CNT_W'(0)));
    go   = !need || out_free;
    hold = item.valid && !go;
    push = need && out_free;

    if (item.flush) begin
      grp.bytes = {flush_byte, (OUT_W-BYTE_W)'(0)};
      grp.cnt   = CNT_W'(1);
      grp.vbits = VB_W'(pend);
      grp.last  = 1'b1;
      grp.total = total;
    end else begin
      grp.bytes = aligned[ACC_W-1 -: OUT_W];
      grp.cnt   = nb;
      grp.vbits = VB_W'(BYTE_W);
      grp.last  = 1'b0;
      grp.total = total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      pend  <= '0;
      total <= '0;
    end else if (item.valid && go) begin
      if (item.flush) begin
        acc   <= '0;
        pend  <= '0;
        total <= '0;
      end else begin
        acc   <= acc_next;
        pend  <= r[PEND_W-1:0];
        total <= total_next;
      end
    end
  end

endmodule

// ----- hw/rtl/hbpe_out.sv -----
// ---------------------------------------------------------------------------
// hbpe_out
// result buffer: holds one group and sends it a byte per beat
// ---------------------------------------------------------------------------
module hbpe_out
  import hbpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  group_t             grp,
  input  logic               stall,
  output logic               valid,
  output logic               out_free,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [VB_W-1:0]    valid_bits,
  output logic               last,
  output logic [TOT_W-1:0]   total_bits
);

  logic [OUT_W-1:0] data;
  logic [CNT_W-1:0] cnt;
  logic             taken;

  assign taken      = valid && !stall;
  assign out_free   = !valid || (taken && (cnt == CNT_W'(1)));
  assign out_byte   = data[OUT_W-1 -: BYTE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (push) begin
      valid <= 1'b1;
      cnt   <= grp.cnt;
    end else if (taken) begin
      valid <= (cnt != CNT_W'(1));
      cnt   <= cnt - CNT_W'(1);
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      data       <= grp.bytes;
      valid_bits <= grp.vbits;
      last       <= grp.last;
      total_bits <= grp.total;
    end else if (taken) begin
      data <= data << BYTE_W;
    end
  end

endmodule

// ----- hw/rtl/hbpe_checker.sv -----
// ---------------------------------------------------------------------------
// hbpe_checker
// port-level checks of the huffman bit packer, bound to the top level
// ---------------------------------------------------------------------------
`include "huffman_bit_packing_encoder_assert.svh"

module hbpe_checker
  import hbpe_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               sym_stall,
  input logic               byte_valid,
  input logic               byte_stall,
  input logic [BYTE_W-1:0]  out_byte,
  input logic [VB_W-1:0]    valid_bits,
  input logic               last,
  input logic [TOT_W-1:0]   total_bits
);

  // stalled result beat stays and holds its payload
  `HBPE_ASSERT_NEXT(a_out_hold, byte_valid && byte_stall,
    byte_valid && $stable(out_byte) && $stable(valid_bits) && $stable(last)
      && $stable(total_bits),
    "stalled result beat changed")

  // input is only held back by a pending result
  `HBPE_ASSERT_NOW(a_stall_cause, sym_stall, byte_valid, "input stalled with no result pending")

  // bytes ahead of the flush are always full
  `HBPE_ASSERT_NOW(a_full_byte, byte_valid && !last,
    valid_bits == VB_W'(BYTE_W), "partial byte without last")

  // flush byte never claims more than a byte
  `HBPE_ASSERT_NOW(a_flush_bits, byte_valid && last,
    valid_bits <= VB_W'(BYTE_W), "flush byte too many bits")

endmodule

bind huffman_bit_packing_encoder hbpe_checker u_hbpe_checker (
  .clk        (clk),
  .rst        (rst),
  .sym_stall  (sym_stall),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .out_byte   (out_byte),
  .valid_bits (valid_bits),
  .last       (last),
  .total_bits (total_bits)
);
